[hdl/lottery_scheduler_defines.svh]
// assertion helpers for the scheduler
`ifndef LOTTERY_SCHEDULER_DEFINES_SVH
`define LOTTERY_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define LS_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("scheduler check failed");

// next-cycle implication
`define LS_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("scheduler check failed");

`endif

[hdl/ls_pkg.sv]
`timescale 1ns / 1ps
package ls_pkg;
   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 4;
   localparam int BURST_W    = 16;
   localparam int TICKET_W   = 8;
   localparam int RND_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int DRAW_W     = 12;
   localparam int TIME_W     = 20;
   localparam int SLICE_W    = 16;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ACTIVE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_LOAD  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT   = 1'b1;

   localparam logic [TIME_W-1:0] CLOCK_MAX = 20'hFFFFF;
endpackage

[hdl/ls_ram.sv]
`timescale 1ns / 1ps
module ls_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/ls_div.sv]
`timescale 1ns / 1ps
module ls_div #(
   parameter int DIV_W = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ls_pkg::RND_W-1:0]   dividend,
   input  logic [DIV_W-1:0]           divisor,
   output logic                       done,
   output logic [DIV_W-1:0]           remainder
);
   localparam int STEP_W = $clog2(ls_pkg::RND_W + 1);

   logic                     busy_ff;
   logic                     done_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [ls_pkg::RND_W-1:0] shift_ff;
   logic [DIV_W-1:0]         div_ff;
   logic [DIV_W-1:0]         rem_ff;
   logic [DIV_W:0]           trial;
   logic [DIV_W:0]           diff;
   logic [DIV_W-1:0]         rem_in;

   always_comb begin
      trial  = {rem_ff, shift_ff[ls_pkg::RND_W-1]};
      diff   = trial - {1'b0, div_ff};
      rem_in = (trial >= {1'b0, div_ff}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            step_ff  <= '0;
            rem_ff   <= '0;
            shift_ff <= dividend;
            div_ff   <= divisor;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shift_ff <= {shift_ff[ls_pkg::RND_W-2:0], 1'b0};
            step_ff  <= step_ff + 1'b1;
            if (step_ff == STEP_W'(ls_pkg::RND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

[hdl/lottery_scheduler.sv]
// lottery scheduler: entry table in one registered-read RAM, one command per transfer
// work: load and unknown command walk the N entries in use once; restart sweeps all
//   MAX_ENTRIES, then walks N; a draw does three table walks plus a 16-step divider
// throughput: one command at a time; the next is taken while the result waits at the output
// reset: table reads as zero, clock zero, quantum 1, entry count 1; no clearing pass
`timescale 1ns / 1ps
`include "lottery_scheduler_defines.svh"
module lottery_scheduler #(
   parameter int MAX_ENTRIES = 16,
   parameter int WORK_BITS   = 16,
   parameter int TICKET_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ls_pkg::CMD_W-1:0]        req_command,
   input  logic [ls_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [ls_pkg::BURST_W-1:0]      req_burst_length,
   input  logic [ls_pkg::TICKET_W-1:0]     req_ticket_count,
   input  logic [ls_pkg::RND_W-1:0]        req_random_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ls_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ls_pkg::INDEX_W-1:0]      rsp_winner,
   output logic [ls_pkg::DRAW_W-1:0]       rsp_draw_value,
   output logic [ls_pkg::DRAW_W-1:0]       rsp_ticket_sum,
   output logic [ls_pkg::TIME_W-1:0]       rsp_start_time,
   output logic [ls_pkg::SLICE_W-1:0]      rsp_slice_length,
   output logic                            rsp_finished,
   output logic [ls_pkg::TIME_W-1:0]       rsp_finish_time,
   output logic [ls_pkg::TIME_W-1:0]       rsp_wait_time,
   output logic                            rsp_all_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ls_pkg::CSR_DATA_W-1:0]   csr_data
);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W = TICKET_BITS + $clog2(MAX_ENTRIES);
   localparam int MEM_W = 2 * WORK_BITS + TICKET_BITS;
   localparam int CMP_W = (WORK_BITS > ls_pkg::TIME_W) ? WORK_BITS : ls_pkg::TIME_W;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SWEEP, S_SUM, S_DIV, S_PICK, S_UPDATE, S_CHECK, S_OUT
   } state_type;

   state_type                   state_ff;
   logic [ls_pkg::CMD_W-1:0]    cmd_ff;
   logic [ls_pkg::INDEX_W-1:0]  idx_ff;
   logic [WORK_BITS-1:0]        burst_ff;
   logic [TICKET_BITS-1:0]      tick_ff;
   logic [ls_pkg::RND_W-1:0]    rnd_ff;
   logic [ls_pkg::SLICE_W-1:0]  quantum_ff;
   logic [ls_pkg::COUNT_W-1:0]  count_ff;
   logic [ls_pkg::TIME_W-1:0]   clock_ff;
   logic [MAX_ENTRIES-1:0]      valid_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        pend_ff;
   logic [IDX_W-1:0]            ridx_ff;
   logic [SUM_W-1:0]            sum_ff;
   logic [SUM_W-1:0]            acc_ff;
   logic [SUM_W-1:0]            draw_ff;
   logic                        found_ff;
   logic [IDX_W-1:0]            win_ff;
   logic [WORK_BITS-1:0]        wburst_ff;
   logic [TICKET_BITS-1:0]      wtick_ff;
   logic [WORK_BITS-1:0]        wrem_ff;
   logic                        any_ff;
   logic [ls_pkg::STATUS_W-1:0] r_status_ff;
   logic [ls_pkg::INDEX_W-1:0]  r_winner_ff;
   logic [ls_pkg::DRAW_W-1:0]   r_draw_ff;
   logic [ls_pkg::DRAW_W-1:0]   r_sum_ff;
   logic [ls_pkg::TIME_W-1:0]   r_start_ff;
   logic [ls_pkg::SLICE_W-1:0]  r_slice_ff;
   logic                        r_fin_ff;
   logic [ls_pkg::TIME_W-1:0]   r_ftime_ff;
   logic [ls_pkg::TIME_W-1:0]   r_wait_ff;
   logic                        rsp_valid_ff;
   logic [ls_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ls_pkg::INDEX_W-1:0]  rsp_winner_ff;
   logic [ls_pkg::DRAW_W-1:0]   rsp_draw_ff;
   logic [ls_pkg::DRAW_W-1:0]   rsp_sum_ff;
   logic [ls_pkg::TIME_W-1:0]   rsp_start_ff;
   logic [ls_pkg::SLICE_W-1:0]  rsp_slice_ff;
   logic                        rsp_fin_ff;
   logic [ls_pkg::TIME_W-1:0]   rsp_ftime_ff;
   logic [ls_pkg::TIME_W-1:0]   rsp_wait_ff;
   logic                        rsp_done_ff;

   logic [CNT_W-1:0]           used;
   logic [CNT_W-1:0]           limit;
   logic                       scanning;
   logic                       issue;
   logic                       scan_end;
   logic                       ram_we;
   logic [IDX_W-1:0]           ram_waddr;
   logic [MEM_W-1:0]           ram_wdata;
   logic [MEM_W-1:0]           ram_q;
   logic                       ent_ok;
   logic [WORK_BITS-1:0]       e_burst;
   logic [TICKET_BITS-1:0]     e_tick;
   logic [WORK_BITS-1:0]       e_rem;
   logic [SUM_W-1:0]           acc_next;
   logic                       load_bad;
   logic                       load_in_range;
   logic [ls_pkg::SLICE_W-1:0] q_eff;
   logic [ls_pkg::SLICE_W-1:0] slice;
   logic [ls_pkg::TIME_W:0]    t_sum;
   logic [ls_pkg::TIME_W-1:0]  t_new;
   logic [WORK_BITS-1:0]       new_rem;
   logic [ls_pkg::TIME_W-1:0]  wait_val;
   logic [CMP_W-1:0]           wait_diff;
   logic                       div_start;
   logic                       div_done;
   logic [SUM_W-1:0]           div_rem;

   always_comb begin
      used          = (32'(count_ff) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(count_ff);
      limit         = (state_ff == S_SWEEP) ? CNT_W'(MAX_ENTRIES) : used;
      scanning      = (state_ff == S_SWEEP) || (state_ff == S_SUM) ||
                      (state_ff == S_PICK) || (state_ff == S_CHECK);
      issue         = scanning && (cnt_ff < limit);
      scan_end      = !issue && !pend_ff;
      ent_ok        = pend_ff && valid_ff[ridx_ff];
      e_burst       = ent_ok ? ram_q[MEM_W-1 -: WORK_BITS] : '0;
      e_tick        = ent_ok ? ram_q[WORK_BITS +: TICKET_BITS] : '0;
      e_rem         = ent_ok ? ram_q[WORK_BITS-1:0] : '0;
      acc_next      = acc_ff + SUM_W'(e_tick);
      load_bad      = (burst_ff == '0) || (tick_ff == '0);
      load_in_range = 32'(idx_ff) < MAX_ENTRIES;
      q_eff         = (quantum_ff == '0) ? ls_pkg::SLICE_W'(1) : quantum_ff;
      slice         = (CMP_W'(wrem_ff) < CMP_W'(q_eff)) ? ls_pkg::SLICE_W'(wrem_ff) : q_eff;
      t_sum         = {1'b0, clock_ff} + (ls_pkg::TIME_W + 1)'(slice);
      t_new         = t_sum[ls_pkg::TIME_W] ? ls_pkg::CLOCK_MAX : t_sum[ls_pkg::TIME_W-1:0];
      new_rem       = wrem_ff - WORK_BITS'(slice);
      wait_diff     = CMP_W'(t_new) - CMP_W'(wburst_ff);
      wait_val      = (CMP_W'(t_new) >= CMP_W'(wburst_ff)) ?
                      ls_pkg::TIME_W'(wait_diff) : '0;
      div_start     = (state_ff == S_SUM) && scan_end && (sum_ff != '0);

      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      priority if (state_ff == S_EXEC && cmd_ff == ls_pkg::CMD_LOAD && !load_bad &&
                   load_in_range) begin
         ram_we    = 1'b1;
         ram_waddr = IDX_W'(idx_ff);
         ram_wdata = {burst_ff, tick_ff, burst_ff};
      end else if (state_ff == S_SWEEP && ent_ok) begin
         ram_we    = 1'b1;
         ram_waddr = ridx_ff;
         ram_wdata = {e_burst, e_tick, e_burst};
      end else if (state_ff == S_UPDATE) begin
         ram_we    = 1'b1;
         ram_waddr = win_ff;
         ram_wdata = {wburst_ff, wtick_ff, new_rem};
      end
   end

   ls_ram #(.WIDTH(MEM_W), .DEPTH(MAX_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   ls_div #(.DIV_W(SUM_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rnd_ff),
      .divisor   (sum_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= ls_pkg::SLICE_W'(1);
         count_ff   <= ls_pkg::COUNT_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            ls_pkg::CSR_QUANTUM: quantum_ff <= csr_data;
            ls_pkg::CSR_COUNT:   count_ff   <= csr_data[ls_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         clock_ff     <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (scanning) begin
            pend_ff <= issue;
            ridx_ff <= cnt_ff[IDX_W-1:0];
            if (issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_command;
                  idx_ff   <= req_entry_index;
                  burst_ff <= WORK_BITS'(req_burst_length);
                  tick_ff  <= TICKET_BITS'(req_ticket_count);
                  rnd_ff   <= req_random_value;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               r_status_ff <= ls_pkg::ST_OK;
               r_winner_ff <= '0;
               r_draw_ff   <= '0;
               r_sum_ff    <= '0;
               r_start_ff  <= '0;
               r_slice_ff  <= '0;
               r_fin_ff    <= 1'b0;
               r_ftime_ff  <= '0;
               r_wait_ff   <= '0;
               cnt_ff      <= '0;
               pend_ff     <= 1'b0;
               any_ff      <= 1'b0;
               sum_ff      <= '0;
               unique case (cmd_ff)
                  ls_pkg::CMD_LOAD: begin
                     if (load_bad) begin
                        r_status_ff <= ls_pkg::ST_BAD_LOAD;
                     end else if (load_in_range) begin
                        valid_ff[IDX_W'(idx_ff)] <= 1'b1;
                     end
                     state_ff <= S_CHECK;
                  end
                  ls_pkg::CMD_RESTART: begin
                     clock_ff <= '0;
                     state_ff <= S_SWEEP;
                  end
                  ls_pkg::CMD_DRAW: state_ff <= S_SUM;
                  default:          state_ff <= S_CHECK;
               endcase
            end
            S_SWEEP: begin
               if (scan_end) begin
                  cnt_ff   <= '0;
                  state_ff <= S_CHECK;
               end
            end
            S_SUM: begin
               if (e_rem != '0) begin
                  sum_ff <= sum_ff + SUM_W'(e_tick);
               end
               if (scan_end) begin
                  cnt_ff <= '0;
                  if (sum_ff == '0) begin
                     r_status_ff <= ls_pkg::ST_NO_ACTIVE;
                     state_ff    <= S_CHECK;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  draw_ff  <= div_rem + 1'b1;
                  acc_ff   <= '0;
                  found_ff <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               if (e_rem != '0 && !found_ff) begin
                  acc_ff <= acc_next;
                  if (draw_ff <= acc_next) begin
                     found_ff  <= 1'b1;
                     win_ff    <= ridx_ff;
                     wburst_ff <= e_burst;
                     wtick_ff  <= e_tick;
                     wrem_ff   <= e_rem;
                  end
               end
               if (scan_end) begin
                  cnt_ff <= '0;
                  if (found_ff) begin
                     state_ff <= S_UPDATE;
                  end else begin
                     r_status_ff <= ls_pkg::ST_NO_ACTIVE;
                     state_ff    <= S_CHECK;
                  end
               end
            end
            S_UPDATE: begin
               clock_ff    <= t_new;
               r_winner_ff <= ls_pkg::INDEX_W'(win_ff);
               r_draw_ff   <= ls_pkg::DRAW_W'(draw_ff);
               r_sum_ff    <= ls_pkg::DRAW_W'(sum_ff);
               r_start_ff  <= clock_ff;
               r_slice_ff  <= slice;
               if (new_rem == '0) begin
                  r_fin_ff   <= 1'b1;
                  r_ftime_ff <= t_new;
                  r_wait_ff  <= wait_val;
               end
               cnt_ff   <= '0;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (e_rem != '0) begin
                  any_ff <= 1'b1;
               end
               if (scan_end) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= r_status_ff;
                  rsp_winner_ff <= r_winner_ff;
                  rsp_draw_ff   <= r_draw_ff;
                  rsp_sum_ff    <= r_sum_ff;
                  rsp_start_ff  <= r_start_ff;
                  rsp_slice_ff  <= r_slice_ff;
                  rsp_fin_ff    <= r_fin_ff;
                  rsp_ftime_ff  <= r_ftime_ff;
                  rsp_wait_ff   <= r_wait_ff;
                  rsp_done_ff   <= !any_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_winner       = rsp_winner_ff;
   assign rsp_draw_value   = rsp_draw_ff;
   assign rsp_ticket_sum   = rsp_sum_ff;
   assign rsp_start_time   = rsp_start_ff;
   assign rsp_slice_length = rsp_slice_ff;
   assign rsp_finished     = rsp_fin_ff;
   assign rsp_finish_time  = rsp_ftime_ff;
   assign rsp_wait_time    = rsp_wait_ff;
   assign rsp_all_done     = rsp_done_ff;

   `LS_ASSERT_NOW(a_div_done_in_div, div_done, state_ff == S_DIV)
   `LS_ASSERT_NOW(a_write_states, ram_we,
      state_ff == S_EXEC || state_ff == S_SWEEP || state_ff == S_UPDATE)
   `LS_ASSERT_NOW(a_winner_has_work, state_ff == S_UPDATE, wrem_ff != '0 && found_ff)
   `LS_ASSERT_NEXT(a_update_to_check, state_ff == S_UPDATE, state_ff == S_CHECK)
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
   localparam int TABLE_SIZE = 16;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 120;
   localparam logic [ls_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [ls_pkg::STATUS_W-1:0] status;
      logic [ls_pkg::INDEX_W-1:0]  winner;
      logic [ls_pkg::DRAW_W-1:0]   draw_value;
      logic [ls_pkg::DRAW_W-1:0]   ticket_sum;
      logic [ls_pkg::TIME_W-1:0]   start_time;
      logic [ls_pkg::SLICE_W-1:0]  slice_length;
      logic                        finished;
      logic [ls_pkg::TIME_W-1:0]   finish_time;
      logic [ls_pkg::TIME_W-1:0]   wait_time;
      logic                        all_done;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ls_pkg::CMD_W-1:0] req_command = '0;
   logic [ls_pkg::INDEX_W-1:0] req_entry_index = '0;
   logic [ls_pkg::BURST_W-1:0] req_burst_length = '0;
   logic [ls_pkg::TICKET_W-1:0] req_ticket_count = '0;
   logic [ls_pkg::RND_W-1:0] req_random_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ls_pkg::STATUS_W-1:0] rsp_status;
   logic [ls_pkg::INDEX_W-1:0] rsp_winner;
   logic [ls_pkg::DRAW_W-1:0] rsp_draw_value;
   logic [ls_pkg::DRAW_W-1:0] rsp_ticket_sum;
   logic [ls_pkg::TIME_W-1:0] rsp_start_time;
   logic [ls_pkg::SLICE_W-1:0] rsp_slice_length;
   logic rsp_finished;
   logic [ls_pkg::TIME_W-1:0] rsp_finish_time;
   logic [ls_pkg::TIME_W-1:0] rsp_wait_time;
   logic rsp_all_done;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ls_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ls_pkg::CSR_DATA_W-1:0] csr_data = '0;

   lottery_scheduler u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_entry_index(req_entry_index),
      .req_burst_length(req_burst_length), .req_ticket_count(req_ticket_count),
      .req_random_value(req_random_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_winner(rsp_winner),
      .rsp_draw_value(rsp_draw_value), .rsp_ticket_sum(rsp_ticket_sum),
      .rsp_start_time(rsp_start_time), .rsp_slice_length(rsp_slice_length),
      .rsp_finished(rsp_finished), .rsp_finish_time(rsp_finish_time),
      .rsp_wait_time(rsp_wait_time), .rsp_all_done(rsp_all_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // scheduler state as predicted
   logic [ls_pkg::BURST_W-1:0]  burst_tbl [TABLE_SIZE];
   logic [ls_pkg::TICKET_W-1:0] ticket_tbl [TABLE_SIZE];
   logic [ls_pkg::BURST_W-1:0]  left_tbl [TABLE_SIZE];
   logic [ls_pkg::TIME_W-1:0]   sched_clock;
   logic [ls_pkg::SLICE_W-1:0]  quantum_reg;
   logic [ls_pkg::COUNT_W-1:0]  count_reg;

   sched_result_type pending_results [$];
   int mismatches = 0;
   int results_seen = 0;
   int draws_sent = 0;
   int finishes_seen = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   function automatic int entries_in_use();
      return (count_reg > TABLE_SIZE) ? TABLE_SIZE : int'(count_reg);
   endfunction

   function automatic sched_result_type schedule_step(logic [ls_pkg::CMD_W-1:0] cmd,
         logic [ls_pkg::INDEX_W-1:0] idx, logic [ls_pkg::BURST_W-1:0] burst,
         logic [ls_pkg::TICKET_W-1:0] tix, logic [ls_pkg::RND_W-1:0] rnd);
      sched_result_type r;
      int n;
      int sum;
      int draw;
      int acc;
      int win;
      int q;
      int slice;
      int t;
      bit found;
      bit idle_all;
      r = '0;
      n = entries_in_use();
      if (cmd == ls_pkg::CMD_LOAD) begin
         if (burst == 0 || tix == 0) begin
            r.status = ls_pkg::ST_BAD_LOAD;
         end else begin
            burst_tbl[idx] = burst;
            ticket_tbl[idx] = tix;
            left_tbl[idx] = burst;
         end
      end else if (cmd == ls_pkg::CMD_RESTART) begin
         for (int i = 0; i < TABLE_SIZE; i++) left_tbl[i] = burst_tbl[i];
         sched_clock = '0;
      end else if (cmd == ls_pkg::CMD_DRAW) begin
         sum = 0;
         for (int i = 0; i < n; i++) if (left_tbl[i] != 0) sum += int'(ticket_tbl[i]);
         if (sum == 0) begin
            r.status = ls_pkg::ST_NO_ACTIVE;
         end else begin
            draw = (int'(rnd) % sum) + 1;
            acc = 0;
            win = 0;
            found = 0;
            for (int i = 0; i < n; i++) begin
               if (!found && left_tbl[i] != 0) begin
                  acc += int'(ticket_tbl[i]);
                  if (draw <= acc) begin
                     win = i;
                     found = 1;
                  end
               end
            end
            q = (quantum_reg == 0) ? 1 : int'(quantum_reg);
            slice = (int'(left_tbl[win]) < q) ? int'(left_tbl[win]) : q;
            t = int'(sched_clock) + slice;
            if (t > int'(ls_pkg::CLOCK_MAX)) t = int'(ls_pkg::CLOCK_MAX);
            left_tbl[win] = left_tbl[win] - ls_pkg::BURST_W'(slice);
            r.winner = ls_pkg::INDEX_W'(win);
            r.draw_value = ls_pkg::DRAW_W'(draw);
            r.ticket_sum = ls_pkg::DRAW_W'(sum);
            r.start_time = sched_clock;
            r.slice_length = ls_pkg::SLICE_W'(slice);
            sched_clock = ls_pkg::TIME_W'(t);
            if (left_tbl[win] == 0) begin
               r.finished = 1'b1;
               r.finish_time = ls_pkg::TIME_W'(t);
               r.wait_time = (t >= int'(burst_tbl[win])) ?
                             ls_pkg::TIME_W'(t - int'(burst_tbl[win])) : '0;
            end
         end
      end
      idle_all = 1;
      for (int i = 0; i < n; i++) if (left_tbl[i] != 0) idle_all = 0;
      r.all_done = idle_all;
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result check and receiver stall
   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type exp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_winner, rsp_draw_value, rsp_ticket_sum, rsp_start_time,
                   rsp_slice_length, rsp_finished, rsp_finish_time, rsp_wait_time,
                   rsp_all_done};
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               exp = pending_results.pop_front();
               if (got.finished) finishes_seen++;
               if (got !== exp) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_command(logic [ls_pkg::CMD_W-1:0] cmd,
         logic [ls_pkg::INDEX_W-1:0] idx, logic [ls_pkg::BURST_W-1:0] burst,
         logic [ls_pkg::TICKET_W-1:0] tix, logic [ls_pkg::RND_W-1:0] rnd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_index <= idx;
      req_burst_length <= burst;
      req_ticket_count <= tix;
      req_random_value <= rnd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(schedule_step(cmd, idx, burst, tix, rnd));
      if (cmd == ls_pkg::CMD_DRAW) draws_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [ls_pkg::CSR_IDX_W-1:0] idx,
         logic [ls_pkg::CSR_DATA_W-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == ls_pkg::CSR_QUANTUM) quantum_reg = val;
      else count_reg = val[ls_pkg::COUNT_W-1:0];
   endtask

   task automatic test_directed();
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'hFFFF);
      send_command(ls_pkg::CMD_LOAD, 4'd0, 16'd0, 8'd5, 16'd0);
      send_command(ls_pkg::CMD_LOAD, 4'd0, 16'd3, 8'd0, 16'd0);
      send_command(ls_pkg::CMD_LOAD, 4'd0, 16'hFFFF, 8'hFF, 16'd0);
      send_command(ls_pkg::CMD_LOAD, 4'd15, 16'd2, 8'd1, 16'd0);
      send_command(CMD_UNKNOWN, 4'hF, 16'hFFFF, 8'hFF, 16'hFFFF);
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'd0);
      write_csr(ls_pkg::CSR_COUNT, 16'd16);
      write_csr(ls_pkg::CSR_QUANTUM, 16'hFFFF);
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'hFFFF);
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'd0);
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'd0);
      send_command(ls_pkg::CMD_RESTART, 4'd0, 16'd0, 8'd0, 16'd0);
      write_csr(ls_pkg::CSR_QUANTUM, 16'd0);
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'd255);
      write_csr(ls_pkg::CSR_COUNT, 16'd31);
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'd256);
      write_csr(ls_pkg::CSR_COUNT, 16'd0);
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'd1);
      write_csr(ls_pkg::CSR_COUNT, 16'd1);
      send_command(ls_pkg::CMD_DRAW, 4'd0, 16'd0, 8'd0, 16'd7);
   endtask

   // a table load, a restart and a run of draws; some noise mixed in
   task automatic test_random_runs(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         write_csr(ls_pkg::CSR_QUANTUM, ls_pkg::CSR_DATA_W'(($urandom_range(9) == 0) ?
                   $urandom() : $urandom_range(1, 40)));
         write_csr(ls_pkg::CSR_COUNT, ls_pkg::CSR_DATA_W'(($urandom_range(9) == 0) ?
                   $urandom_range(0, 31) : $urandom_range(2, 16)));
         repeat ($urandom_range(2, 8)) begin
            send_command(ls_pkg::CMD_LOAD, ls_pkg::INDEX_W'($urandom()),
                         ls_pkg::BURST_W'(($urandom_range(15) == 0) ?
                                          $urandom() : $urandom_range(1, 120)),
                         ($urandom_range(20) == 0) ? 8'd0 : ls_pkg::TICKET_W'($urandom()),
                         ls_pkg::RND_W'($urandom()));
            sent++;
         end
         send_command(ls_pkg::CMD_RESTART, ls_pkg::INDEX_W'($urandom()),
                      ls_pkg::BURST_W'($urandom()), ls_pkg::TICKET_W'($urandom()),
                      ls_pkg::RND_W'($urandom()));
         sent++;
         repeat ($urandom_range(10, 40)) begin
            if ($urandom_range(19) == 0)
               send_command(ls_pkg::CMD_W'($urandom()), ls_pkg::INDEX_W'($urandom()),
                            ls_pkg::BURST_W'($urandom()), ls_pkg::TICKET_W'($urandom()),
                            ls_pkg::RND_W'($urandom()));
            else
               send_command(ls_pkg::CMD_DRAW, ls_pkg::INDEX_W'($urandom()),
                            ls_pkg::BURST_W'($urandom()), ls_pkg::TICKET_W'($urandom()),
                            ls_pkg::RND_W'($urandom()));
            sent++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         burst_tbl[i] = '0;
         ticket_tbl[i] = '0;
         left_tbl[i] = '0;
      end
      sched_clock = '0;
      quantum_reg = 16'd1;
      count_reg = 5'd1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 7;
      recv_idle_pct = 83;
      test_random_runs(330);
      send_idle_pct = 83;
      recv_idle_pct = 7;
      test_random_runs(330);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_runs(340);
      drain();
      $display("covered %0d results, %0d draws, %0d finished entries", results_seen,
               draws_sent, finishes_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+hdl
hdl/ls_pkg.sv
hdl/ls_ram.sv
hdl/ls_div.sv
hdl/lottery_scheduler.sv
bench/tb.sv
